### rtl/lfu_pkg.sv
// shared types and constants of the lfu cache table
`default_nettype none

package lfu_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_COUNT_BITS = 16;

    // configuration register
    localparam int          CAP_BITS  = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;
    localparam int          APB_DW    = 32;

    // operation codes carried in the input tuser
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // status flags of one result item
    typedef struct packed {
        logic evicted;
        logic found;
    } t_flags;

endpackage

`default_nettype wire

### rtl/lfu_victim.sv
// victim selection tree: lowest use count, oldest entry among equals
`default_nettype none

module lfu_victim #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic [ENTRIES-1:0]         i_valid,
    input  logic [COUNT_BITS-1:0]      i_count [ENTRIES],
    input  logic [$clog2(ENTRIES)-1:0] i_rank  [ENTRIES],
    output logic [$clog2(ENTRIES)-1:0] o_idx
);
    import lfu_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int LEAVES = 2 ** IDX_W;
    localparam int NODES = 2 * LEAVES - 1;

    logic                  nd_vld  [NODES];
    logic [COUNT_BITS-1:0] nd_cnt  [NODES];
    logic [IDX_W-1:0]      nd_rank [NODES];
    logic [IDX_W-1:0]      nd_idx  [NODES];

    // leaves, padded with empty slots up to a power of two
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < ENTRIES) begin : g_real
            assign nd_vld[LEAVES-1+i]  = i_valid[i];
            assign nd_cnt[LEAVES-1+i]  = i_count[i];
            assign nd_rank[LEAVES-1+i] = i_rank[i];
            assign nd_idx[LEAVES-1+i]  = IDX_W'(i);
        end else begin : g_pad
            assign nd_vld[LEAVES-1+i]  = 1'b0;
            assign nd_cnt[LEAVES-1+i]  = '0;
            assign nd_rank[LEAVES-1+i] = '0;
            assign nd_idx[LEAVES-1+i]  = '0;
        end
    end

    // compare nodes, higher rank means touched longer ago
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
        logic take_b;
        assign take_b = nd_vld[2*n+2] &&
                        (!nd_vld[2*n+1] ||
                         nd_cnt[2*n+2] < nd_cnt[2*n+1] ||
                         (nd_cnt[2*n+2] == nd_cnt[2*n+1] &&
                          nd_rank[2*n+2] > nd_rank[2*n+1]));
        assign nd_vld[n]  = take_b ? nd_vld[2*n+2]  : nd_vld[2*n+1];
        assign nd_cnt[n]  = take_b ? nd_cnt[2*n+2]  : nd_cnt[2*n+1];
        assign nd_rank[n] = take_b ? nd_rank[2*n+2] : nd_rank[2*n+1];
        assign nd_idx[n]  = take_b ? nd_idx[2*n+2]  : nd_idx[2*n+1];
    end

    assign o_idx = nd_idx[0];

endmodule

`default_nettype wire

### rtl/lfu_slots.sv
// slot store with lookup, use count, recency and replacement update
`default_nettype none

module lfu_slots #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lfu_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic                          i_mode,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic [lfu_pkg::CAP_BITS-1:0]  i_capacity,
    output lfu_pkg::t_flags               o_flags,
    output logic [VALUE_BITS-1:0]         o_read_value,
    output logic [KEY_BITS-1:0]           o_evicted_key
);
    import lfu_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CAP_W  = (FILL_W > CAP_BITS) ? FILL_W : CAP_BITS;
    localparam int THR_W  = IDX_W + 1;

    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [KEY_BITS-1:0]   r_key   [ENTRIES];
    logic [KEY_BITS-1:0]   n_key   [ENTRIES];
    logic [VALUE_BITS-1:0] r_value [ENTRIES];
    logic [VALUE_BITS-1:0] n_value [ENTRIES];
    logic [COUNT_BITS-1:0] r_count [ENTRIES];
    logic [COUNT_BITS-1:0] n_count [ENTRIES];
    logic [IDX_W-1:0]      r_rank  [ENTRIES];
    logic [IDX_W-1:0]      n_rank  [ENTRIES];
    logic [FILL_W-1:0]     r_filled, n_filled;

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    free_oh;
    logic [IDX_W-1:0]      hit_idx, free_idx, victim_idx, tgt_idx;
    logic [VALUE_BITS-1:0] hit_value;
    logic [CAP_W-1:0]      cap_eff;
    logic [THR_W-1:0]      thr;
    logic                  hit, is_get, upd, ins, full, evict, act;

    lfu_victim #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_victim (
        .i_valid (r_valid),
        .i_count (r_count),
        .i_rank  (r_rank),
        .o_idx   (victim_idx)
    );

    assign free_oh = ~r_valid & (r_valid + ENTRIES'(1));

    always_comb begin
        hit_idx   = '0;
        free_idx  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_key);
            if (match[i]) begin
                hit_idx   = hit_idx | IDX_W'(i);
                hit_value = hit_value | r_value[i];
            end
            if (free_oh[i]) begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
        hit = |match;

        // capacity above the slot count acts as the slot count
        cap_eff = (CAP_W'(i_capacity) > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES)
                                                         : CAP_W'(i_capacity);
        is_get = (i_mode == MODE_GET);
        upd    = hit && (is_get || cap_eff != '0);
        ins    = !is_get && cap_eff != '0 && !hit;
        full   = CAP_W'(r_filled) >= cap_eff;
        evict  = ins && full;
        act    = i_go && (upd || ins);

        tgt_idx = upd ? hit_idx : (evict ? victim_idx : free_idx);
        // a fresh slot ranks below all others, so every valid entry ages
        thr = (upd || evict) ? {1'b0, r_rank[tgt_idx]} : THR_W'(ENTRIES);

        n_valid  = r_valid;
        n_filled = r_filled;
        for (int i = 0; i < ENTRIES; i++) begin
            n_key[i]   = r_key[i];
            n_value[i] = r_value[i];
            n_count[i] = r_count[i];
            n_rank[i]  = r_rank[i];
            if (act) begin
                if (tgt_idx == IDX_W'(i)) begin
                    n_rank[i] = '0;
                    if (ins) begin
                        n_valid[i] = 1'b1;
                        n_key[i]   = i_key;
                        n_value[i] = i_value;
                        n_count[i] = COUNT_BITS'(1);
                    end else begin
                        if (!is_get) begin
                            n_value[i] = i_value;
                        end
                        // count saturates at all ones
                        if (!(&r_count[i])) begin
                            n_count[i] = r_count[i] + COUNT_BITS'(1);
                        end
                    end
                end else if (r_valid[i] && ({1'b0, r_rank[i]} < thr)) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end
        end
        if (act && ins && !full) begin
            n_filled = r_filled + FILL_W'(1);
        end

        o_flags.found   = upd;
        o_flags.evicted = evict;
        o_read_value    = (is_get && hit) ? hit_value : '0;
        o_evicted_key   = evict ? r_key[victim_idx] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_filled <= '0;
        end else begin
            r_valid  <= n_valid;
            r_filled <= n_filled;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            r_key[i]   <= n_key[i];
            r_value[i] <= n_value[i];
            r_count[i] <= n_count[i];
            r_rank[i]  <= n_rank[i];
        end
    end

    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_filled))
        else $error("fill count differs from number of valid slots");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && hit |-> $onehot(match))
        else $error("key stored in more than one slot");

    a_victim_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && evict |-> r_valid[victim_idx])
        else $error("victim slot is not in use");

    a_free_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && ins && !full |-> $onehot(free_oh))
        else $error("insert below capacity without a free slot");

endmodule

`default_nettype wire

### rtl/lfu_cache_table.sv
// top level of the lfu cache table: stream channels, config port, pipeline registers
//
// fully associative key/value cache with least-frequently-used replacement,
// ties among equal use counts going to the entry touched longest ago
// input channel s_*: tuser is the mode (get or put), tdata carries key and value
// output channel m_*: one result item per input item, in order
//   tuser holds found and evicted, tdata the read value and the evicted key
// apb port: one register, capacity, at byte address 0; pready is tied high
//   write it only while no item is in flight
// an accepted item sits in the input register until the result register is free
//   or being emptied; the lookup/update logic then loads the result register,
//   which drives m_tvalid
// throughput: one item per cycle while the receiver does not stall; the limit is
//   the combinational key compare and victim tree feeding the slot update
// reset (synchronous, active low): all slots empty, capacity 16, both
//   pipeline registers empty
// when the receiver stalls the result register holds, the input register
//   still fills, and s_tready drops once both are occupied
`default_nettype none

module lfu_cache_table #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lfu_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // input channel
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // [KEY_BITS-1:0] lookup_key, then write_value, zero padded to bytes
    input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]    s_tdata,
    // [0] mode
    input  logic                                        s_tuser,
    // output channel
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // [VALUE_BITS-1:0] read_value, then evicted_key, zero padded to bytes
    output logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]    m_tdata,
    // [0] found, [1] evicted
    output logic [1:0]                                  m_tuser,
    // configuration port
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [1:0]                                  paddr,
    input  logic [lfu_pkg::APB_DW-1:0]                  pwdata,
    output logic [lfu_pkg::APB_DW-1:0]                  prdata,
    output logic                                        pready
);
    import lfu_pkg::*;

    localparam int TD_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;

    // capacity register
    logic [CAP_BITS-1:0]   r_cap;

    // input register
    logic                  r_in_vld;
    logic                  r_mode;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;

    // result register
    logic                  r_out_vld;
    t_flags                r_flags;
    logic [VALUE_BITS-1:0] r_rval;
    logic [KEY_BITS-1:0]   r_ekey;

    t_flags                res_flags;
    logic [VALUE_BITS-1:0] res_rval;
    logic [KEY_BITS-1:0]   res_ekey;
    logic                  advance, take_in;

    // apb: single register, every address decodes to it
    assign pready = 1'b1;
    assign prdata = APB_DW'(r_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_cap <= pwdata[CAP_BITS-1:0];
        end
    end

    // the item in the input register is processed once the result register
    // is free or being emptied
    assign advance  = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_in_vld || advance;
    assign take_in  = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_mode <= s_tuser;
            r_key  <= s_tdata[KEY_BITS-1:0];
            r_val  <= s_tdata[KEY_BITS +: VALUE_BITS];
        end
        if (advance) begin
            r_flags <= res_flags;
            r_rval  <= res_rval;
            r_ekey  <= res_ekey;
        end
    end

    lfu_slots #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_slots (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (advance),
        .i_mode        (r_mode),
        .i_key         (r_key),
        .i_value       (r_val),
        .i_capacity    (r_cap),
        .o_flags       (res_flags),
        .o_read_value  (res_rval),
        .o_evicted_key (res_ekey)
    );

    assign m_tvalid   = r_out_vld;
    assign m_tdata    = TD_W'({r_ekey, r_rval});
    assign m_tuser[0] = r_flags.found;
    assign m_tuser[1] = r_flags.evicted;

endmodule

`default_nettype wire

### sim/lfu_cache_table_tb.sv
// self-checking testbench for the lfu cache table: stream traffic, capacity writes, scoreboard

module lfu_cache_table_tb;

    import lfu_pkg::*;

    localparam int         SLOTS        = DEF_ENTRIES;
    localparam int         KEY_W        = DEF_KEY_BITS;
    localparam int         VAL_W        = DEF_VALUE_BITS;
    localparam int         CNT_W        = DEF_COUNT_BITS;
    localparam int         DATA_W       = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam logic [1:0] ADDR_CAPACITY = 2'd0;
    localparam int         POOL_SIZE    = 24;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         EXP_DEPTH    = 64;
    localparam int         PHASE_ITEMS  = 170;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_lookup_result;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // [31:0] lookup_key, [63:32] write_value
    logic [DATA_W-1:0] s_tdata  = '0;
    // [0] mode
    logic              s_tuser  = MODE_GET;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [31:0] read_value, [63:32] evicted_key
    logic [DATA_W-1:0] m_tdata;
    // [0] found, [1] evicted
    logic [1:0]        m_tuser;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [1:0]        paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lfu_cache_table DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the cache contents
    logic             tag_valid [SLOTS];
    logic [KEY_W-1:0] tag_key   [SLOTS];
    logic [VAL_W-1:0] tag_value [SLOTS];
    logic [CNT_W-1:0] tag_uses  [SLOTS];
    int               tag_rank  [SLOTS];
    int               fill_count = 0;
    logic [CAP_BITS-1:0] cap_shadow = CAP_RESET;

    // expected results, written at acceptance and read back in order
    t_lookup_result exp_fifo [EXP_DEPTH];
    int             exp_wr = 0;
    int             exp_rd = 0;
    t_lookup_result got_result;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int errors       = 0;
    int items_sent   = 0;
    int hits_seen    = 0;
    int evicts_seen  = 0;
    int cap_writes   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // most recently touched gets rank 0, entries that were more recent move down one
    function automatic void touch_entry(int s);
        for (int i = 0; i < SLOTS; i++)
            if (tag_valid[i] && i != s && tag_rank[i] < tag_rank[s])
                tag_rank[i]++;
        tag_rank[s] = 0;
    endfunction

    function automatic void bump_entry(int s);
        if (tag_uses[s] != {CNT_W{1'b1}})
            tag_uses[s]++;
        touch_entry(s);
    endfunction

    function automatic t_lookup_result cache_predict(logic op, logic [KEY_W-1:0] key,
                                                     logic [VAL_W-1:0] val);
        t_lookup_result r;
        int hit;
        int slot;
        int lim;
        r   = '0;
        hit = -1;
        lim = (cap_shadow > SLOTS) ? SLOTS : int'(cap_shadow);
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tag_valid[i] && tag_key[i] == key)
                hit = i;
        if (op == MODE_GET) begin
            if (hit >= 0) begin
                bump_entry(hit);
                r.found      = 1'b1;
                r.read_value = tag_value[hit];
            end
            return r;
        end
        // zero capacity: puts do nothing at all
        if (lim == 0)
            return r;
        if (hit >= 0) begin
            tag_value[hit] = val;
            bump_entry(hit);
            r.found = 1'b1;
            return r;
        end
        slot = -1;
        if (fill_count >= lim) begin
            // victim: lowest use count, then the one touched longest ago
            for (int i = 0; i < SLOTS; i++)
                if (tag_valid[i] && (slot < 0 || tag_uses[i] < tag_uses[slot] ||
                    (tag_uses[i] == tag_uses[slot] && tag_rank[i] > tag_rank[slot])))
                    slot = i;
            if (slot < 0)
                return r;
            r.evicted     = 1'b1;
            r.evicted_key = tag_key[slot];
        end else begin
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && !tag_valid[i])
                    slot = i;
            if (slot < 0)
                return r;
            fill_count++;
            tag_rank[slot]  = SLOTS;
            tag_valid[slot] = 1'b1;
        end
        tag_key[slot]   = key;
        tag_value[slot] = val;
        tag_uses[slot]  = 1;
        touch_entry(slot);
        return r;
    endfunction

    // random stall on the result side
    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // result checker, oldest prediction first
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (exp_wr == exp_rd) begin
                $error("result item with nothing pending: tuser %b tdata %h", m_tuser, m_tdata);
                errors++;
            end else begin
                got_result = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_tuser[0] !== got_result.found) begin
                    $error("found: expected %b, got %b", got_result.found, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[VAL_W-1:0] !== got_result.read_value) begin
                    $error("read_value: expected %h, got %h",
                           got_result.read_value, m_tdata[VAL_W-1:0]);
                    errors++;
                end
                if (m_tuser[1] !== got_result.evicted) begin
                    $error("evicted: expected %b, got %b", got_result.evicted, m_tuser[1]);
                    errors++;
                end
                if (m_tdata[VAL_W +: KEY_W] !== got_result.evicted_key) begin
                    $error("evicted_key: expected %h, got %h",
                           got_result.evicted_key, m_tdata[VAL_W +: KEY_W]);
                    errors++;
                end
            end
        end
    end

    // send one item; tvalid stays high on return so back-to-back items need no gap
    task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        t_lookup_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do @(posedge i_clk); while (!s_tready);
        r = cache_predict(op, key, val);
        exp_fifo[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
        items_sent++;
        if (r.found && op == MODE_GET)
            hits_seen++;
        if (r.evicted)
            evicts_seen++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // capacity write, only ever issued with nothing in flight
    task automatic write_capacity(logic [CAP_BITS-1:0] cap);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= APB_DW'(cap);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_shadow = cap;
        cap_writes++;
    endtask

    // extremes of key and value, both operations, misses, updates
    task automatic test_directed_ops();
        send_item(MODE_GET, '0, '1);
        send_item(MODE_PUT, '0, '1);
        send_item(MODE_PUT, '1, '0);
        send_item(MODE_GET, '0, '0);
        send_item(MODE_GET, '1, '1);
        send_item(MODE_PUT, '0, 32'h5a5a_a5a5);
        send_item(MODE_GET, '0, '0);
        send_item(MODE_GET, 32'h8000_0001, '0);
        send_item(MODE_PUT, 32'h0000_0001, 32'h1111_1111);
        send_item(MODE_PUT, 32'h0000_0002, 32'h2222_2222);
        send_item(MODE_GET, 32'h0000_0001, '0);
    endtask

    // small capacities: frequency first, recency on ties, and lowered below the fill level
    task automatic test_replacement();
        write_capacity(5'd2);
        send_item(MODE_PUT, 32'h0000_0a0a, 32'h0000_00aa);
        send_item(MODE_PUT, 32'h0000_0b0b, 32'h0000_00bb);
        send_item(MODE_GET, 32'h0000_0a0a, '0);
        send_item(MODE_PUT, 32'h0000_0c0c, 32'h0000_00cc);
        send_item(MODE_PUT, 32'h0000_0d0d, 32'h0000_00dd);
        send_item(MODE_GET, 32'h0000_0b0b, '0);
        write_capacity(5'd1);
        send_item(MODE_PUT, 32'h0000_0e0e, 32'h0000_00ee);
        send_item(MODE_PUT, 32'h0000_0e0e, 32'h0000_0eee);
        send_item(MODE_GET, 32'h0000_0e0e, '0);
    endtask

    // zero capacity: puts are dropped but stored entries still hit
    task automatic test_zero_capacity();
        write_capacity(5'd0);
        send_item(MODE_PUT, 32'h0000_0f0f, 32'h0000_00ff);
        send_item(MODE_GET, 32'h0000_0f0f, '0);
        send_item(MODE_PUT, 32'h0000_0e0e, 32'hdead_beef);
        send_item(MODE_GET, 32'h0000_0e0e, '0);
        send_item(MODE_GET, '0, '0);
    endtask

    // capacity beyond the slot count acts as a full table
    task automatic test_oversize_capacity();
        write_capacity(5'd31);
        for (int i = 0; i < SLOTS + 6; i++)
            send_item(MODE_PUT, 32'h1000_0000 + i, $urandom);
        send_item(MODE_GET, 32'h1000_0000 + SLOTS + 5, '0);
    endtask

    // build up one key's use count, then check it is never the victim
    task automatic test_hot_entry();
        logic [KEY_W-1:0] hot_key;
        hot_key = 32'hc0de_0001;
        write_capacity(5'd16);
        send_item(MODE_PUT, hot_key, 32'h0bad_cafe);
        for (int i = 0; i < SLOTS + 8; i++)
            send_item(MODE_GET, hot_key, '0);
        for (int i = 0; i < SLOTS + 4; i++)
            send_item(MODE_PUT, 32'h2000_0000 + i, $urandom);
        send_item(MODE_PUT, hot_key, 32'h600d_f00d);
        send_item(MODE_GET, hot_key, '0);
    endtask

    // mixed traffic from a small key pool so hits and evictions are frequent
    task automatic test_random_traffic();
        int idle_tab  [3] = '{33, 52, 0};
        int stall_tab [3] = '{52, 33, 0};
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            case (ph)
                0: write_capacity(5'd16);
                1: write_capacity(5'($urandom_range(1, 15)));
                default: write_capacity(5'd31);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until the table has answered everything
                if (n == PHASE_ITEMS / 2)
                    write_capacity(5'($urandom_range(1, 31)));
                key = ($urandom_range(9) == 0) ? KEY_W'($urandom)
                                               : key_pool[$urandom_range(POOL_SIZE - 1)];
                case ($urandom_range(7))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = $urandom;
                endcase
                send_item($urandom_range(1) ? MODE_PUT : MODE_GET, key, val);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tag_valid[i] = 1'b0;
            tag_key[i]   = '0;
            tag_value[i] = '0;
            tag_uses[i]  = '0;
            tag_rank[i]  = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_replacement();
        test_zero_capacity();
        test_oversize_capacity();
        test_hot_entry();
        test_random_traffic();
        wait_drained();
        $display("run covered %0d items: %0d get hits, %0d evictions, %0d capacity writes",
                 items_sent, hits_seen, evicts_seen, cap_writes);
        $display("capacities 0, 1, 2, 16, 31 and random, with idling on each side and none");
        if (errors == 0) begin
            $display("lfu_cache_table_tb OK");
        end else begin
            $display("lfu_cache_table_tb NOT OK");
        end
        $finish;
    end

    // safety net well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", exp_wr - exp_rd);
        $display("lfu_cache_table_tb NOT OK");
        $finish;
    end

endmodule
